// ===== hdl/aasr_pkg.sv =====
// Shared package for the strided axis sum reduction block.
// Holds field widths, register indexes and the control structs used by
// every module; no dependencies.
package aasr_pkg;

    localparam int DATA_W        = 32;   // Q16.16 input element parts
    localparam int ACC_W         = 48;   // Q32.16 sums
    localparam int STRIDE_W      = 11;   // inner_stride register
    localparam int LEN_W         = 16;   // axis_length register
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_INNER_DEF = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER_STRIDE = 2'd0,
        REG_AXIS_LENGTH  = 2'd1
    } t_cfg_reg;

    // Role of one element within its block, decided when it is accepted.
    typedef struct packed {
        logic first;   // first slice: loads the accumulator
        logic last;    // last slice: the sum leaves the block
    } t_slot_flags;

    // Stage after acceptance, shared by both lanes.
    typedef struct packed {
        logic first;
        logic last;
        logic use_fwd; // previous write hit the address just read
    } t_s1_ctl;

    // Per-cycle commands to an accumulator lane.
    typedef struct packed {
        logic rd_en;   // an element is accepted: read its accumulator
        logic wr_en;   // the stage-one element stores its partial sum
        logic first;
        logic use_fwd;
    } t_lane_ctl;

endpackage

// ===== hdl/aasr_if.sv =====
// Handshake channels of the strided axis sum reduction block.
// Depends on aasr_pkg for the payload widths.
interface aasr_in_if import aasr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] real_part;
    logic signed [DATA_W-1:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface aasr_out_if import aasr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] sum_real;
    logic signed [ACC_W-1:0] sum_imag;

    modport source (output valid, output sum_real, output sum_imag, input ready);
    modport sink   (input valid, input sum_real, input sum_imag, output ready);
endinterface

// ===== hdl/array_axis_sum_reduction_core.sv =====
// Top level of the strided axis sum reduction block.
// Depends on aasr_pkg, aasr_if, aasr_ctrl and aasr_lane.

// Complex elements arrive one per transfer in column-major order and are
// summed along one axis, set by inner_stride (register 0) and axis_length
// (register 1); an axis length of 1 passes every element straight through.
// The block takes one element per clock cycle for as long as the result
// side keeps up: each element needs a single read-modify-write of its
// accumulator entry in each of the two lanes (real and imaginary), done as
// a registered memory read in the cycle of acceptance and an add-and-write
// in the next. A sum is loaded into the output register when its element
// leaves stage one. The input is held off only while a last-slice element
// waits behind a result that has not yet been taken. The accumulator
// memories hold MAX_INNER entries each and need no clearing after reset,
// since every block loads them afresh on its first slice.
// Registers are to be written only while no element is in flight.
module array_axis_sum_reduction_core import aasr_pkg::*; #(
    parameter int MAX_INNER = MAX_INNER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    aasr_in_if.sink               i_elem,
    aasr_out_if.source            o_sum
);

    localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    logic            accept;
    logic            s1_adv;
    logic            acc_we;
    logic [AW-1:0]   slot_pos;
    t_slot_flags     slot_flags;
    t_lane_ctl       lane_ctl;

    // Stage one: the element whose accumulator read is in flight.
    logic            r_s1_valid, n_s1_valid;
    t_s1_ctl         r_s1, n_s1;
    logic [AW-1:0]   r_s1_pos;

    logic            r_out_valid, n_out_valid;
    logic [ACC_W-1:0] r_sum_real;
    logic [ACC_W-1:0] r_sum_imag;
    logic [ACC_W-1:0] lane_sum_real;
    logic [ACC_W-1:0] lane_sum_imag;

    // A non-final element always moves on; a final one needs the output
    // register to be empty or emptying in this cycle.
    assign s1_adv = r_s1_valid && (!r_s1.last || !r_out_valid || o_sum.ready);
    assign acc_we = s1_adv && !r_s1.last;

    assign i_elem.ready = !r_s1_valid || s1_adv;
    assign accept       = i_elem.valid && i_elem.ready;

    aasr_ctrl #(
        .MAX_INNER (MAX_INNER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_pos      (slot_pos),
        .o_flags    (slot_flags)
    );

    // The read for a newly accepted element happens at the same edge as the
    // write of the element ahead of it, so a same-address hit is remembered
    // and the lane takes its own last sum instead of the stale read.
    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (accept) begin
            n_s1_valid   = 1'b1;
            n_s1.first   = slot_flags.first;
            n_s1.last    = slot_flags.last;
            n_s1.use_fwd = acc_we && (r_s1_pos == slot_pos);
        end else if (s1_adv) begin
            n_s1_valid   = 1'b0;
            n_s1.use_fwd = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_adv && r_s1.last) begin
            n_out_valid = 1'b1;
        end else if (o_sum.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s1        <= n_s1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= slot_pos;
        end
        if (s1_adv && r_s1.last) begin
            r_sum_real <= lane_sum_real;
            r_sum_imag <= lane_sum_imag;
        end
    end

    assign lane_ctl.rd_en   = accept;
    assign lane_ctl.wr_en   = acc_we;
    assign lane_ctl.first   = r_s1.first;
    assign lane_ctl.use_fwd = r_s1.use_fwd;

    aasr_lane #(
        .MAX_INNER (MAX_INNER)
    ) u_lane_real (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_rd_addr (slot_pos),
        .i_wr_addr (r_s1_pos),
        .i_data    (i_elem.real_part),
        .o_sum     (lane_sum_real)
    );

    aasr_lane #(
        .MAX_INNER (MAX_INNER)
    ) u_lane_imag (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_rd_addr (slot_pos),
        .i_wr_addr (r_s1_pos),
        .i_data    (i_elem.imag_part),
        .o_sum     (lane_sum_imag)
    );

    // The two lane results are merged into one output transfer.
    assign o_sum.valid    = r_out_valid;
    assign o_sum.sum_real = r_sum_real;
    assign o_sum.sum_imag = r_sum_imag;

endmodule

// ===== hdl/aasr_ctrl.sv =====
// Configuration registers and position counters of the reduction block.
// Depends on aasr_pkg.
module aasr_ctrl import aasr_pkg::*; #(
    parameter int MAX_INNER = MAX_INNER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    output logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] o_pos,
    output t_slot_flags           o_flags
);

    localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW = ((AW > STRIDE_W) ? AW : STRIDE_W) + 1;

    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [LEN_W-1:0]    r_length, n_length;
    logic [AW-1:0]       r_inner, n_inner;
    logic [LEN_W-1:0]    r_slice, n_slice;
    logic [STRIDE_W-1:0] cfg_stride;
    logic [LEN_W-1:0]    cfg_length;
    logic                row_end;
    logic                last_slice;

    // Stored values are already the effective ones: zero and oversize clamped.
    assign cfg_stride = i_cfg_data[STRIDE_W-1:0];
    assign cfg_length = i_cfg_data[LEN_W-1:0];

    assign row_end    = (CW'(r_inner) + CW'(1)) >= CW'(r_stride);
    assign last_slice = ((LEN_W+1)'(r_slice) + (LEN_W+1)'(1)) >= (LEN_W+1)'(r_length);

    always_comb begin
        n_stride = r_stride;
        n_length = r_length;
        n_inner  = r_inner;
        n_slice  = r_slice;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_INNER_STRIDE: begin
                    if (cfg_stride == '0) begin
                        n_stride = STRIDE_W'(1);
                    end else if (32'(cfg_stride) > MAX_INNER) begin
                        n_stride = STRIDE_W'(MAX_INNER);
                    end else begin
                        n_stride = cfg_stride;
                    end
                    n_inner = '0;
                    n_slice = '0;
                end
                REG_AXIS_LENGTH: begin
                    n_length = (cfg_length == '0) ? LEN_W'(1) : cfg_length;
                    n_inner  = '0;
                    n_slice  = '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (row_end) begin
                n_inner = '0;
                n_slice = last_slice ? '0 : r_slice + LEN_W'(1);
            end else begin
                n_inner = r_inner + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_W'(1);
            r_length <= LEN_W'(1);
            r_inner  <= '0;
            r_slice  <= '0;
        end else begin
            r_stride <= n_stride;
            r_length <= n_length;
            r_inner  <= n_inner;
            r_slice  <= n_slice;
        end
    end

    assign o_pos         = r_inner;
    assign o_flags.first = (r_slice == '0);
    assign o_flags.last  = last_slice;

endmodule

// ===== hdl/aasr_lane.sv =====
// One accumulator lane: a memory of partial sums with its adder and a
// one-entry forward path. Depends on aasr_pkg.
module aasr_lane import aasr_pkg::*; #(
    parameter int MAX_INNER = MAX_INNER_DEF
) (
    input  logic              i_clk,
    input  t_lane_ctl         i_ctl,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] i_rd_addr,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_data,
    output logic [ACC_W-1:0]  o_sum
);

    logic [ACC_W-1:0]  r_mem [MAX_INNER];
    logic [ACC_W-1:0]  r_rd;
    logic [ACC_W-1:0]  r_fwd;
    logic [DATA_W-1:0] r_x;
    logic [ACC_W-1:0]  x_ext;
    logic [ACC_W-1:0]  base;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_x <= i_data;
        end
        if (i_ctl.wr_en) begin
            r_fwd <= o_sum;
        end
    end

    assign x_ext = {{(ACC_W-DATA_W){r_x[DATA_W-1]}}, r_x};
    assign base  = i_ctl.use_fwd ? r_fwd : r_rd;
    assign o_sum = i_ctl.first ? x_ext : base + x_ext;

endmodule

// ===== hdl/aasr_checker.sv =====
// Port-level checks for the strided axis sum reduction block, bound to
// the top level. Depends on aasr_pkg and array_axis_sum_reduction_core.
module aasr_checker import aasr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ACC_W-1:0] i_sum_real,
    input logic [ACC_W-1:0] i_sum_imag
);

    // A result that is not taken stays offered, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_sum_real) && $stable(i_sum_imag))
        else $error("result changed or dropped while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    // The input is held off only behind a stalled result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused while the result side is free");

    // A refused input element meets a held result on the next cycle too,
    // unless the result is taken.
    a_stall_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready && !i_out_ready |=> i_out_valid)
        else $error("stalled result vanished");

endmodule

bind array_axis_sum_reduction_core aasr_checker u_aasr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_elem.valid),
    .i_in_ready  (i_elem.ready),
    .i_out_valid (o_sum.valid),
    .i_out_ready (o_sum.ready),
    .i_sum_real  (o_sum.sum_real),
    .i_sum_imag  (o_sum.sum_imag)
);

// ===== tb/array_axis_sum_reduction_core_tb.sv =====
// Self-checking testbench for the strided axis sum reduction block.
// Depends on aasr_pkg, aasr_if and array_axis_sum_reduction_core from the RTL.
// Expected sums come from a predictor inside this module that follows each accepted element.
module array_axis_sum_reduction_core_tb import aasr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that the block has no register behind; writes to
    // them must be dropped without restarting the block.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

    // Cycles left after the last expected sum before a register write, so
    // that the accumulator write of an element without a result has landed.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 200;

    typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} t_idle_mode;

    typedef struct {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } t_element;

    typedef struct {
        logic [ACC_W-1:0] sum_real;
        logic [ACC_W-1:0] sum_imag;
    } t_sum;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    aasr_in_if  elem_ch ();
    aasr_out_if sum_ch ();

    array_axis_sum_reduction_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_elem     (elem_ch),
        .o_sum      (sum_ch)
    );

    always #4 i_clk = ~i_clk;

    // Elements waiting for the driver, and sums waiting for the block.
    t_element    elem_queue[$];
    t_sum        expected_sums[$];
    int unsigned elems_queued   = 0;
    int unsigned elems_accepted = 0;
    int unsigned error_count    = 0;

    t_idle_mode  send_mode = IDLE_FULL;
    t_idle_mode  recv_mode = IDLE_FULL;
    int unsigned send_wait;
    int unsigned recv_wait;

    // Predictor state: the register copies, the position within the
    // current slice, the slice within the block and the partial sums.
    logic [STRIDE_W-1:0] cfg_stride = 11'd1;
    logic [LEN_W-1:0]    cfg_length = 16'd1;
    int unsigned         elem_pos   = 0;
    int unsigned         slice_idx  = 0;
    logic [ACC_W-1:0]    acc_re [MAX_INNER_DEF];
    logic [ACC_W-1:0]    acc_im [MAX_INNER_DEF];

    function automatic int unsigned draw_gap(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
            default:    return $urandom_range(0, 14);
        endcase
    endfunction

    // Adds one element into its accumulator slot. The first slice of a block
    // loads the slot, later slices add to it, and on the last slice the sum
    // is expected at the output instead of being stored. A zero stride acts
    // as one, a stride beyond the memory acts as the memory size, and a zero
    // length acts as one, which is plain pass-through.
    function automatic void accumulate_element(input logic [DATA_W-1:0] re,
                                               input logic [DATA_W-1:0] im);
        int unsigned      stride_eff;
        int unsigned      len_eff;
        logic [ACC_W-1:0] sum_re;
        logic [ACC_W-1:0] sum_im;
        bit               last_slice;

        stride_eff = (cfg_stride == 0) ? 1 : cfg_stride;
        if (stride_eff > MAX_INNER_DEF) begin
            stride_eff = MAX_INNER_DEF;
        end
        len_eff = (cfg_length == 0) ? 1 : cfg_length;
        if (elem_pos >= stride_eff) begin
            elem_pos = 0;
        end
        if (slice_idx >= len_eff) begin
            slice_idx = 0;
        end

        sum_re = {{(ACC_W-DATA_W){re[DATA_W-1]}}, re};
        sum_im = {{(ACC_W-DATA_W){im[DATA_W-1]}}, im};
        if (slice_idx != 0) begin
            sum_re = sum_re + acc_re[elem_pos];
            sum_im = sum_im + acc_im[elem_pos];
        end

        last_slice = (slice_idx + 1 >= len_eff);
        if (last_slice) begin
            expected_sums.push_back('{sum_real: sum_re, sum_imag: sum_im});
        end else begin
            acc_re[elem_pos] = sum_re;
            acc_im[elem_pos] = sum_im;
        end

        if (elem_pos + 1 >= stride_eff) begin
            elem_pos  = 0;
            slice_idx = last_slice ? 0 : slice_idx + 1;
        end else begin
            elem_pos++;
        end
    endfunction

    // One register write. Only the two real registers restart the block;
    // the predictor follows at the edge where the block takes the write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_INNER_STRIDE: begin
                cfg_stride = value[STRIDE_W-1:0];
                elem_pos   = 0;
                slice_idx  = 0;
            end
            REG_AXIS_LENGTH: begin
                cfg_length = value[LEN_W-1:0];
                elem_pos   = 0;
                slice_idx  = 0;
            end
            default: ;
        endcase
    endtask

    task automatic queue_element(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
        elem_queue.push_back('{re: re, im: im});
        elems_queued++;
    endtask

    // The block counts as idle once every queued element has been taken and
    // every expected sum has come back; a short pause then covers an element
    // whose only effect is an accumulator write.
    task automatic wait_idle();
        while (elems_accepted != elems_queued || expected_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly full-range values, with the extremes, zero and small numbers
    // mixed in so that sums of extremes and cancellations both turn up.
    function automatic logic [DATA_W-1:0] random_part();
        case ($urandom_range(0, 7))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    // Element driver. After each transfer it holds valid low for the drawn
    // number of cycles, then presents the next pending element.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_ch.valid <= 1'b0;
            send_wait     <= 0;
        end else if (!elem_ch.valid || elem_ch.ready) begin
            if (send_wait != 0) begin
                elem_ch.valid <= 1'b0;
                send_wait     <= send_wait - 1;
            end else if (elem_queue.size() != 0) begin
                elem_ch.valid     <= 1'b1;
                elem_ch.real_part <= elem_queue[0].re;
                elem_ch.imag_part <= elem_queue[0].im;
                send_wait         <= draw_gap(send_mode);
                void'(elem_queue.pop_front());
            end else begin
                elem_ch.valid <= 1'b0;
            end
        end
    end

    // Result side. After each transfer ready drops for the drawn number of
    // cycles, so that stalls fall on every phase of the block's work.
    always @(posedge i_clk) begin : sum_sink
        int unsigned stall;
        if (!i_rst_n) begin
            sum_ch.ready <= 1'b0;
            recv_wait    <= 0;
        end else if (sum_ch.valid && sum_ch.ready) begin
            stall = draw_gap(recv_mode);
            recv_wait    <= stall;
            sum_ch.ready <= (stall == 0);
        end else if (recv_wait != 0) begin
            recv_wait    <= recv_wait - 1;
            sum_ch.ready <= (recv_wait == 1);
        end else begin
            sum_ch.ready <= 1'b1;
        end
    end

    // Monitor. Both channels are sampled at the rising edge, where a
    // transfer happens; each accepted element feeds the predictor and each
    // accepted sum is compared with the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_sum want;
        if (i_rst_n) begin
            if (elem_ch.valid && elem_ch.ready) begin
                accumulate_element(elem_ch.real_part, elem_ch.imag_part);
                elems_accepted++;
            end
            if (sum_ch.valid && sum_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t ns: unexpected sum, expected none, got real %h imag %h",
                             $time, sum_ch.sum_real, sum_ch.sum_imag);
                    error_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (sum_ch.sum_real !== want.sum_real) begin
                        $display("%0t ns: sum_real expected %h, got %h",
                                 $time, want.sum_real, sum_ch.sum_real);
                        error_count++;
                    end
                    if (sum_ch.sum_imag !== want.sum_imag) begin
                        $display("%0t ns: sum_imag expected %h, got %h",
                                 $time, want.sum_imag, sum_ch.sum_imag);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned         kind;
        int unsigned         stride_val;
        int unsigned         len_val;
        int unsigned         stride_eff;
        int unsigned         block_len;
        int unsigned         n_items;
        int unsigned         random_items;
        logic [CFG_DATA_W-1:0] stride_data;

        random_items      = 0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        elem_ch.valid     = 1'b0;
        elem_ch.real_part = '0;
        elem_ch.imag_part = '0;
        sum_ch.ready      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset the block passes elements through.
        queue_element(DATA_MAX, DATA_MIN);
        queue_element(DATA_MIN, DATA_MAX);
        queue_element('0, -1);
        queue_element(-1, '0);
        wait_idle();

        // A zero stride acts as one: three extremes summed along the axis.
        write_reg(REG_INNER_STRIDE, 16'd0);
        write_reg(REG_AXIS_LENGTH, 16'd3);
        repeat (3) queue_element(DATA_MAX, DATA_MIN);
        repeat (3) queue_element(DATA_MIN, DATA_MAX);
        wait_idle();

        // A zero length acts as one, which is pass-through.
        write_reg(REG_INNER_STRIDE, 16'd2);
        write_reg(REG_AXIS_LENGTH, 16'd0);
        queue_element(32'd1, 32'd2);
        queue_element(-3, '0);
        wait_idle();

        // Writes to unused indexes in the middle of a block change nothing.
        write_reg(REG_AXIS_LENGTH, 16'd2);
        queue_element(32'd5, -7);
        queue_element(DATA_MAX, DATA_MAX);
        wait_idle();
        write_reg(REG_UNUSED_2, 16'hFFFF);
        write_reg(REG_UNUSED_3, 16'h0001);
        queue_element(32'd9, 32'd11);
        queue_element(DATA_MAX, DATA_MIN);
        wait_idle();

        // A register write in the middle of a block restarts it, so the
        // first two elements here never reach a sum.
        write_reg(REG_INNER_STRIDE, 16'd1);
        write_reg(REG_AXIS_LENGTH, 16'd3);
        queue_element(32'h1234_5678, 32'h0BAD_F00D);
        queue_element(-100, 100);
        wait_idle();
        write_reg(REG_AXIS_LENGTH, 16'd3);
        queue_element(32'd1, -1);
        queue_element(32'd2, -2);
        queue_element(32'd3, -3);
        wait_idle();

        // Widest stride: values beyond the memory act as its size, so one
        // full slice of loads is followed by a run of finished sums.
        send_mode  = t_idle_mode'($urandom_range(0, 2));
        recv_mode  = t_idle_mode'($urandom_range(0, 2));
        stride_val = $urandom_range(0, 1) ? MAX_INNER_DEF : $urandom_range(1025, 2047);
        write_reg(REG_INNER_STRIDE, CFG_DATA_W'(stride_val));
        write_reg(REG_AXIS_LENGTH, 16'd2);
        n_items = MAX_INNER_DEF + $urandom_range(8, 40);
        repeat (n_items) queue_element(random_part(), random_part());
        wait_idle();

        // Longest axis: a partial block only, so nothing comes out, and the
        // next register write throws it away.
        write_reg(REG_INNER_STRIDE, CFG_DATA_W'($urandom_range(1, 4)));
        write_reg(REG_AXIS_LENGTH, 16'hFFFF);
        repeat (48) queue_element(random_part(), random_part());
        wait_idle();

        // Random phases, mostly small blocks so that sums come often.
        while (random_items < RANDOM_ITEMS) begin
            send_mode = t_idle_mode'($urandom_range(0, 2));
            recv_mode = t_idle_mode'($urandom_range(0, 2));
            kind      = $urandom_range(0, 9);
            if (kind < 6) begin
                stride_val = $urandom_range(0, 6);
                len_val    = $urandom_range(0, 6);
            end else if (kind < 8) begin
                stride_val = $urandom_range(7, 40);
                len_val    = $urandom_range(1, 3);
            end else begin
                // Pass-through with an arbitrary stride word.
                stride_val = $urandom_range(0, 16'hFFFF);
                len_val    = 1;
            end
            stride_data = CFG_DATA_W'(stride_val);
            if (kind < 8 && $urandom_range(0, 3) == 0) begin
                // Bits above the stride register are ignored.
                stride_data[CFG_DATA_W-1:STRIDE_W] = (CFG_DATA_W-STRIDE_W)'($urandom);
            end

            if ($urandom_range(0, 1)) begin
                write_reg(REG_INNER_STRIDE, stride_data);
                write_reg(REG_AXIS_LENGTH, CFG_DATA_W'(len_val));
            end else begin
                write_reg(REG_AXIS_LENGTH, CFG_DATA_W'(len_val));
                write_reg(REG_INNER_STRIDE, stride_data);
            end
            if ($urandom_range(0, 4) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          CFG_DATA_W'($urandom));
            end

            if (kind >= 8) begin
                n_items = $urandom_range(4, 40);
            end else begin
                stride_eff = (stride_val == 0) ? 1 : stride_val;
                block_len  = stride_eff * ((len_val == 0) ? 1 : len_val);
                n_items    = block_len * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) begin
                    // A trailing partial block, cut off by the next write.
                    n_items += $urandom_range(1, block_len);
                end
            end
            repeat (n_items) begin
                if ($urandom_range(0, 5) == 0) begin
                    queue_element(random_part(), '0);
                end else begin
                    queue_element(random_part(), random_part());
                end
            end
            random_items += n_items;
            wait_idle();
        end

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
